>>> src/pfb_alloc_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
// Used by page_frame_bitmap_allocator; depends on nothing else.
package pfb_alloc_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned FRAME_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned FREE_FRAME_W  = 15;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned RND_W         = CFG_W + 1;
  localparam int unsigned RND_ADD       = 7;   // round up to a multiple of 8
  localparam int unsigned RND_MASK      = 'h7;
  localparam int unsigned FRAME_CNT_RST = 32768;
  localparam int unsigned RECIP_GUARD   = 7;   // extra reciprocal bits, keeps error below 1

  localparam int unsigned MAX_FRAMES_DEF    = 32768;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEST = 2'd0,
    CMD_FREE = 2'd1,
    CMD_TAKE = 2'd2,
    CMD_FIND = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOFREE = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_MOD  = 7'b0010000,
    S_FRD  = 7'b0100000,
    S_FCHK = 7'b1000000
  } state_e;

endpackage

>>> src/page_frame_bitmap_allocator.sv
// Page frame bitmap allocator: free map in a single-port memory under a small sequencer.
// Test, mark free and mark taken check the range, then read and modify the map word; an
// out-of-range frame ends at the range check. Find free reads the map a word at a time
// until one has a free bit or the scan reaches the frame count. busy drops with the strobe.
// Reset: a clearing pass writes every map word free, with busy high.
// Results carry no back-pressure; the receiver cannot stall them.
module page_frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES    = pfb_alloc_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAP_WORD_BITS = pfb_alloc_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [pfb_alloc_pkg::CMD_W-1:0]        command_i,
  input  logic [pfb_alloc_pkg::ADDR_W-1:0]       address_i,
  input  logic                                   cfg_we_i,
  input  logic [pfb_alloc_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                   done_o,
  output logic [pfb_alloc_pkg::STATUS_W-1:0]     status_o,
  output logic                                   frame_is_free_o,
  output logic [pfb_alloc_pkg::FREE_FRAME_W-1:0] free_frame_o
);

  localparam int unsigned FRAME_W   = pfb_alloc_pkg::FRAME_W;
  localparam int unsigned MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned WIDX      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SUM_W     = (CNT_W > pfb_alloc_pkg::RND_W) ? CNT_W
                                                                      : pfb_alloc_pkg::RND_W;
  localparam int unsigned BASE_W    = $clog2(MAX_FRAMES + 2 * MAP_WORD_BITS);
  localparam int unsigned CMP_W     = (BASE_W > FRAME_W) ? BASE_W : FRAME_W;
  localparam int unsigned FF_W      = (BASE_W > pfb_alloc_pkg::FREE_FRAME_W) ? BASE_W
                                                          : pfb_alloc_pkg::FREE_FRAME_W;
  localparam int unsigned DIV_SHIFT = FRAME_W + pfb_alloc_pkg::RECIP_GUARD;
  localparam int unsigned RECIP     = (1 << DIV_SHIFT) / MAP_WORD_BITS;
  localparam int unsigned RECIP_W   = $clog2(RECIP + 1);
  localparam int unsigned PROD_W    = FRAME_W + RECIP_W;
  localparam int unsigned CNT_RST   = (pfb_alloc_pkg::FRAME_CNT_RST > MAX_FRAMES) ? MAX_FRAMES
                                                          : pfb_alloc_pkg::FRAME_CNT_RST;

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [MAP_WORD_BITS-1:0] v);
    logic [BIT_W-1:0] lb;
    lb = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) lb = BIT_W'(i);
    end
    return lb;
  endfunction

  pfb_alloc_pkg::state_e state_q, state_d;
  pfb_alloc_pkg::cmd_e   cmd_q, cmd_d;
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic [WIDX-1:0]       widx_q, widx_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic [BASE_W-1:0]     base_q, base_d;
  logic [CNT_W-1:0]      count_q;

  logic                                   done_q, done_d;
  logic [pfb_alloc_pkg::STATUS_W-1:0]     status_q, status_d;
  logic                                   is_free_q, is_free_d;
  logic [pfb_alloc_pkg::FREE_FRAME_W-1:0] free_frame_q, free_frame_d;

  // map memory
  logic [MAP_WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rd_data_q;
  logic [MAP_WORD_BITS-1:0] mem_wdata;
  logic [WIDX-1:0]          mem_addr;
  logic                     mem_we, mem_re;

  // count in use from the written register
  logic [pfb_alloc_pkg::RND_W-1:0] rnd;
  logic [SUM_W-1:0]                cnt_new;

  // divide by word width: reciprocal estimate, then one correction
  logic [PROD_W-1:0]    prod;
  logic [FRAME_W-1:0]   rem;
  logic                 rem_corr;
  logic [WIDX-1:0]      word_calc;
  logic [BIT_W-1:0]     bit_calc;

  logic [CMP_W-1:0]     frame_ext, count_ext, base_ext, found_ext;
  logic [BASE_W-1:0]    found;
  logic [FF_W-1:0]      found_wide;
  logic [MAP_WORD_BITS-1:0] bit_mask;

  assign rnd = (pfb_alloc_pkg::RND_W'(cfg_wdata_i) + pfb_alloc_pkg::RND_W'(pfb_alloc_pkg::RND_ADD))
               & ~pfb_alloc_pkg::RND_W'(pfb_alloc_pkg::RND_MASK);
  assign cnt_new = (SUM_W'(rnd) > SUM_W'(MAX_FRAMES)) ? SUM_W'(MAX_FRAMES) : SUM_W'(rnd);

  assign prod      = PROD_W'(frame_q) * PROD_W'(RECIP);
  assign rem       = frame_q - FRAME_W'(widx_q) * FRAME_W'(MAP_WORD_BITS);
  assign rem_corr  = (rem >= FRAME_W'(MAP_WORD_BITS));
  assign word_calc = widx_q + WIDX'(rem_corr);
  assign bit_calc  = rem_corr ? BIT_W'(rem - FRAME_W'(MAP_WORD_BITS)) : BIT_W'(rem);

  assign frame_ext  = CMP_W'(frame_q);
  assign count_ext  = CMP_W'(count_q);
  assign base_ext   = CMP_W'(base_q);
  assign found      = base_q + BASE_W'(lowest_bit(rd_data_q));
  assign found_ext  = CMP_W'(found);
  assign found_wide = FF_W'(found);
  assign bit_mask   = MAP_WORD_BITS'(1) << bit_q;

  assign busy = (state_q != pfb_alloc_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    frame_d      = frame_q;
    widx_d       = widx_q;
    bit_d        = bit_q;
    base_d       = base_q;
    done_d       = 1'b0;
    status_d     = pfb_alloc_pkg::ST_OK;
    is_free_d    = 1'b0;
    free_frame_d = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = widx_q;
    mem_wdata    = rd_data_q;

    unique case (state_q)
      pfb_alloc_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
        if (widx_q == WIDX'(MAP_WORDS - 1)) begin
          widx_d  = '0;
          state_d = pfb_alloc_pkg::S_IDLE;
        end else begin
          widx_d = widx_q + WIDX'(1);
        end
      end
      pfb_alloc_pkg::S_IDLE: begin
        if (start) begin
          cmd_d   = pfb_alloc_pkg::cmd_e'(command_i);
          frame_d = address_i[pfb_alloc_pkg::ADDR_W-1:pfb_alloc_pkg::PAGE_SHIFT];
          widx_d  = '0;
          base_d  = '0;
          if (pfb_alloc_pkg::cmd_e'(command_i) == pfb_alloc_pkg::CMD_FIND) begin
            state_d = pfb_alloc_pkg::S_FRD;
          end else begin
            state_d = pfb_alloc_pkg::S_DIV;
          end
        end
      end
      pfb_alloc_pkg::S_DIV: begin
        if (frame_ext >= count_ext) begin
          done_d   = 1'b1;
          status_d = pfb_alloc_pkg::ST_RANGE;
          state_d  = pfb_alloc_pkg::S_IDLE;
        end else begin
          widx_d  = WIDX'(prod >> DIV_SHIFT);
          state_d = pfb_alloc_pkg::S_RD;
        end
      end
      pfb_alloc_pkg::S_RD: begin
        mem_re   = 1'b1;
        mem_addr = word_calc;
        widx_d   = word_calc;
        bit_d    = bit_calc;
        state_d  = pfb_alloc_pkg::S_MOD;
      end
      pfb_alloc_pkg::S_MOD: begin
        done_d  = 1'b1;
        state_d = pfb_alloc_pkg::S_IDLE;
        unique case (cmd_q)
          pfb_alloc_pkg::CMD_TEST: is_free_d = |(rd_data_q & bit_mask);
          pfb_alloc_pkg::CMD_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q | bit_mask;
          end
          pfb_alloc_pkg::CMD_TAKE: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q & ~bit_mask;
          end
          default: ;
        endcase
      end
      pfb_alloc_pkg::S_FRD: begin
        if (base_ext >= count_ext) begin
          done_d   = 1'b1;
          status_d = pfb_alloc_pkg::ST_NOFREE;
          state_d  = pfb_alloc_pkg::S_IDLE;
        end else begin
          mem_re  = 1'b1;
          state_d = pfb_alloc_pkg::S_FCHK;
        end
      end
      pfb_alloc_pkg::S_FCHK: begin
        // the first word with any free bit settles the answer
        if (|rd_data_q) begin
          done_d  = 1'b1;
          state_d = pfb_alloc_pkg::S_IDLE;
          if (found_ext < count_ext) begin
            free_frame_d = found_wide[pfb_alloc_pkg::FREE_FRAME_W-1:0];
          end else begin
            status_d = pfb_alloc_pkg::ST_NOFREE;
          end
        end else begin
          widx_d  = widx_q + WIDX'(1);
          base_d  = base_q + BASE_W'(MAP_WORD_BITS);
          state_d = pfb_alloc_pkg::S_FRD;
        end
      end
      default: state_d = pfb_alloc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfb_alloc_pkg::S_CLR;
      widx_q       <= '0;
      count_q      <= CNT_W'(CNT_RST);
      done_q       <= 1'b0;
      status_q     <= pfb_alloc_pkg::ST_OK;
      is_free_q    <= 1'b0;
      free_frame_q <= '0;
    end else begin
      state_q      <= state_d;
      widx_q       <= widx_d;
      done_q       <= done_d;
      status_q     <= status_d;
      is_free_q    <= is_free_d;
      free_frame_q <= free_frame_d;
      if (cfg_we_i) begin
        count_q <= CNT_W'(cnt_new);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    frame_q <= frame_d;
    bit_q   <= bit_d;
    base_q  <= base_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign frame_is_free_o = is_free_q;
  assign free_frame_o    = free_frame_q;

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without a command in progress");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != pfb_alloc_pkg::ST_OK) |-> (!frame_is_free_o && free_frame_o == '0))
    else $error("error result carries payload");

  a_payload_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_is_free_o || free_frame_o != '0) |-> done_o)
    else $error("result payload outside the strobe");

endmodule
